@@ src/work_descriptor_fifo_assert.svh @@
// Assertion macros shared by the descriptor queue modules.
// Each checks on the rising clock edge and is off while reset is low.
`ifndef WORK_DESCRIPTOR_FIFO_ASSERT_SVH
`define WORK_DESCRIPTOR_FIFO_ASSERT_SVH

// Same-cycle implication
`define WDF_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define WDF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/wdf_pkg.sv @@
package wdf_pkg;

	// Queue depth default and the most results a single run may emit
	localparam int DEFAULT_QUEUE_DEPTH = 64;
	localparam int RESULT_CAP          = 64;

	// Fixed field widths
	localparam int HANDLER_W = 32;
	localparam int WORD_W    = 64;
	localparam int COUNT_W   = 7;

	// Command codes
	localparam logic CMD_SCHEDULE = 1'b0;
	localparam logic CMD_RUN      = 1'b1;

	typedef struct packed {
		logic                 command;
		logic [HANDLER_W-1:0] handler;
		logic [WORD_W-1:0]    argument;
		logic [COUNT_W-1:0]   batch_limit;
	} wdf_req_t;

	typedef struct packed {
		logic                 accepted;
		logic                 entry_valid;
		logic [HANDLER_W-1:0] out_handler;
		logic [WORD_W-1:0]    out_argument;
		logic [WORD_W-1:0]    out_sequence;
		logic [COUNT_W-1:0]   ran_so_far;
		logic                 last;
		logic [COUNT_W-1:0]   pending_count;
		logic [WORD_W-1:0]    executed_total;
		logic [WORD_W-1:0]    dropped_total;
	} wdf_rsp_t;

	// One stored descriptor
	typedef struct packed {
		logic [HANDLER_W-1:0] handler;
		logic [WORD_W-1:0]    argument;
		logic [WORD_W-1:0]    sequence_num;
	} wdf_entry_t;

	// Requests from the controller to the ring
	typedef struct packed {
		logic push;    // write the tail entry
		logic pop;     // retire the head entry
		logic rd_req;  // fetch the head (the new head when popping)
	} wdf_ring_ctrl_t;

	// Ring fill status
	typedef struct packed {
		logic full;
		logic empty;
		logic last_one;
	} wdf_ring_stat_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} wdf_state_t;

endpackage

@@ src/wdf_ring.sv @@
module wdf_ring #(
	parameter int QUEUE_DEPTH = wdf_pkg::DEFAULT_QUEUE_DEPTH,
	parameter int OCC_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wdf_pkg::wdf_ring_ctrl_t ctrl,
	input  wdf_pkg::wdf_entry_t    push_entry,
	output wdf_pkg::wdf_entry_t    rd_entry,
	output logic [OCC_W-1:0]       occupancy,
	output wdf_pkg::wdf_ring_stat_t stat
);
	import wdf_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);

	wdf_entry_t       mem [QUEUE_DEPTH];
	wdf_entry_t       rd_entry_q;
	logic [IDX_W-1:0] wr_idx_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [OCC_W-1:0] occ_q;
	logic [IDX_W-1:0] wr_idx_nxt;
	logic [IDX_W-1:0] rd_idx_nxt;
	logic [IDX_W-1:0] rd_addr;

	// Pointer increments, wrapping at the depth
	assign wr_idx_nxt = (wr_idx_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
	assign rd_idx_nxt = (rd_idx_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;

	// A fetch issued with a pop looks at the entry behind the retiring head
	assign rd_addr = ctrl.pop ? rd_idx_nxt : rd_idx_q;

	// Descriptor storage, one write and one registered read port
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[wr_idx_q] <= push_entry;
		end
		if (ctrl.rd_req) begin
			rd_entry_q <= mem[rd_addr];
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			occ_q    <= '0;
		end else begin
			if (ctrl.push) begin
				wr_idx_q <= wr_idx_nxt;
			end
			if (ctrl.pop) begin
				rd_idx_q <= rd_idx_nxt;
			end
			case ({ctrl.push, ctrl.pop})
				2'b10:   occ_q <= occ_q + 1'b1;
				2'b01:   occ_q <= occ_q - 1'b1;
				default: occ_q <= occ_q;
			endcase
		end
	end

	assign rd_entry      = rd_entry_q;
	assign occupancy     = occ_q;
	assign stat.full     = (occ_q == OCC_W'(QUEUE_DEPTH));
	assign stat.empty    = (occ_q == '0);
	assign stat.last_one = (occ_q == OCC_W'(1));

`include "work_descriptor_fifo_assert.svh"

	`WDF_ASSERT_NOW(a_no_push_full, clk, arst_n, ctrl.push, !stat.full, "push into full ring")
	`WDF_ASSERT_NOW(a_no_pop_empty, clk, arst_n, ctrl.pop, !stat.empty, "pop from empty ring")
	`WDF_ASSERT_NOW(a_occ_bound, clk, arst_n, 1'b1, occ_q <= OCC_W'(QUEUE_DEPTH), "occupancy overflow")

endmodule

@@ src/work_descriptor_fifo.sv @@
// Channel | Role   | Handshake            | Beat
// req     | input  | req_valid, req_stall | wdf_req_t: command, handler, argument, batch_limit
// rsp     | output | rsp_valid, rsp_stall | wdf_rsp_t: drained descriptor plus queue counters
//
// A schedule beat yields one result beat.
// A run on a non-empty ring first fetches the head from the ring memory, then
// drains one entry per cycle while the result side does not stall.
// The single-port read of the ring memory paces the drain.
// Reset clears pointers, counters and control; ring contents stay undefined.
// A stalled result holds the drain; the next request waits until the run ends.
module work_descriptor_fifo #(
	parameter int QUEUE_DEPTH = wdf_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  wdf_pkg::wdf_req_t req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output wdf_pkg::wdf_rsp_t rsp
);
	import wdf_pkg::*;

	localparam int OCC_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int DEPTH_CAP = (QUEUE_DEPTH < RESULT_CAP) ? QUEUE_DEPTH : RESULT_CAP;

	wdf_state_t         state_q, state_d;
	wdf_ring_ctrl_t     ring_ctrl;
	wdf_ring_stat_t     ring_stat;
	wdf_entry_t         push_entry;
	wdf_entry_t         rd_entry;
	logic [OCC_W-1:0]   occ;
	logic [WORD_W-1:0]  seq_q;
	logic [WORD_W-1:0]  exec_q;
	logic [WORD_W-1:0]  drop_q;
	logic [COUNT_W-1:0] limit_q;
	logic [COUNT_W-1:0] ran_q;
	logic [COUNT_W-1:0] limit_d;
	logic [COUNT_W-1:0] ran_next;
	logic               rsp_valid_q;
	wdf_rsp_t           rsp_q, rsp_d;
	logic               rsp_load;
	logic               sched_drop;
	logic               out_free;
	logic               take;
	logic               take_run;
	logic               cont;

	wdf_ring #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.OCC_W       (OCC_W)
	) u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ring_ctrl),
		.push_entry (push_entry),
		.rd_entry   (rd_entry),
		.occupancy  (occ),
		.stat       (ring_stat)
	);

	// Handshake
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || !out_free;
	assign take      = req_valid && !req_stall;
	assign take_run  = take && (req.command == CMD_RUN);

	// Batch limit: zero or above the depth means the depth, capped at the result cap
	always_comb begin
		if (req.batch_limit == '0 || 32'(req.batch_limit) > QUEUE_DEPTH) begin
			limit_d = COUNT_W'(DEPTH_CAP);
		end else if (req.batch_limit > COUNT_W'(RESULT_CAP)) begin
			limit_d = COUNT_W'(RESULT_CAP);
		end else begin
			limit_d = req.batch_limit;
		end
	end

	assign ran_next = ran_q + 1'b1;
	assign cont     = (ran_next < limit_q) && !ring_stat.last_one;

	assign push_entry.handler      = req.handler;
	assign push_entry.argument     = req.argument;
	assign push_entry.sequence_num = seq_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take_run && !ring_stat.empty) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_free && !cont) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Ring requests and result beat
	always_comb begin
		ring_ctrl            = '0;
		rsp_load             = 1'b0;
		sched_drop           = 1'b0;
		rsp_d                = '0;
		rsp_d.pending_count  = COUNT_W'(32'(occ));
		rsp_d.executed_total = exec_q;
		rsp_d.dropped_total  = drop_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (req.command == CMD_SCHEDULE) begin
						rsp_load   = 1'b1;
						rsp_d.last = 1'b1;
						if (req.handler != '0) begin
							if (ring_stat.full) begin
								sched_drop          = 1'b1;
								rsp_d.dropped_total = drop_q + 1'b1;
							end else begin
								ring_ctrl.push      = 1'b1;
								rsp_d.accepted      = 1'b1;
								rsp_d.pending_count = COUNT_W'(32'(occ + 1'b1));
							end
						end
					end else if (ring_stat.empty) begin
						rsp_load   = 1'b1;
						rsp_d.last = 1'b1;
					end else begin
						ring_ctrl.rd_req = 1'b1;
					end
				end
			end
			ST_DRAIN: begin
				if (out_free) begin
					ring_ctrl.pop        = 1'b1;
					ring_ctrl.rd_req     = cont;
					rsp_load             = 1'b1;
					rsp_d.entry_valid    = 1'b1;
					rsp_d.out_handler    = rd_entry.handler;
					rsp_d.out_argument   = rd_entry.argument;
					rsp_d.out_sequence   = rd_entry.sequence_num;
					rsp_d.ran_so_far     = ran_next;
					rsp_d.last           = !cont;
					rsp_d.pending_count  = COUNT_W'(32'(occ - 1'b1));
					rsp_d.executed_total = exec_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Control state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			seq_q       <= WORD_W'(1);
			exec_q      <= '0;
			drop_q      <= '0;
			limit_q     <= '0;
			ran_q       <= '0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_load || (rsp_valid_q && rsp_stall);
			if (ring_ctrl.push) begin
				seq_q <= seq_q + 1'b1;
			end
			if (ring_ctrl.pop) begin
				exec_q <= exec_q + 1'b1;
				ran_q  <= ran_next;
			end
			if (sched_drop) begin
				drop_q <= drop_q + 1'b1;
			end
			if (take_run) begin
				limit_q <= limit_d;
				ran_q   <= '0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`include "work_descriptor_fifo_assert.svh"

	`WDF_ASSERT_NOW(a_drain_nonempty, clk, arst_n, state_q == ST_DRAIN, !ring_stat.empty, "drain with empty ring")
	`WDF_ASSERT_NOW(a_drain_in_limit, clk, arst_n, state_q == ST_DRAIN, ran_q < limit_q, "drain past batch limit")
	`WDF_ASSERT_NOW(a_ran_range, clk, arst_n, rsp_valid_q && rsp_q.entry_valid, (rsp_q.ran_so_far != '0) && (rsp_q.ran_so_far <= COUNT_W'(RESULT_CAP)), "drained beat count out of range")
	`WDF_ASSERT_NEXT(a_fetch_ready, clk, arst_n, ring_ctrl.rd_req, state_q == ST_DRAIN, "head fetched outside a drain")

endmodule

@@ verif/work_descriptor_fifo_checker.sv @@
`timescale 1ns / 100ps

module work_descriptor_fifo_checker #(
	parameter int QUEUE_DEPTH = wdf_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_stall,
	input  wdf_pkg::wdf_req_t req,
	input  logic              rsp_valid,
	input  logic              rsp_stall,
	input  wdf_pkg::wdf_rsp_t rsp,
	output int                error_count,
	output int                results_owed
);
	import wdf_pkg::*;

	// Shadow copy of the descriptor ring
	logic [HANDLER_W-1:0] slot_handler  [QUEUE_DEPTH];
	logic [WORD_W-1:0]    slot_argument [QUEUE_DEPTH];
	logic [WORD_W-1:0]    slot_seq      [QUEUE_DEPTH];
	int                   head_idx;
	int                   tail_idx;
	int                   fill_level;
	logic [WORD_W-1:0]    seq_next;
	logic [WORD_W-1:0]    drained_tally;
	logic [WORD_W-1:0]    dropped_tally;

	// Result beats still owed by the block, oldest first
	wdf_rsp_t owed_beats[$];
	int       errors_seen;

	// Counters shared by every result beat
	function automatic wdf_rsp_t stamp_counts(input wdf_rsp_t beat);
		beat.pending_count  = COUNT_W'(fill_level);
		beat.executed_total = drained_tally;
		beat.dropped_total  = dropped_tally;
		return beat;
	endfunction

	// Apply one request beat to the shadow ring and queue its result beats
	task automatic predict_request(input wdf_req_t beat);
		int       batch;
		int       drained;
		wdf_rsp_t res;
		res = '0;
		if (beat.command == CMD_SCHEDULE) begin
			if (beat.handler != '0) begin
				if (fill_level >= QUEUE_DEPTH) begin
					dropped_tally = dropped_tally + 1'b1;
				end else begin
					slot_handler[tail_idx]  = beat.handler;
					slot_argument[tail_idx] = beat.argument;
					slot_seq[tail_idx]      = seq_next;
					seq_next                = seq_next + 1'b1;
					tail_idx                = (tail_idx + 1) % QUEUE_DEPTH;
					fill_level++;
					res.accepted = 1'b1;
				end
			end
			res.last = 1'b1;
			owed_beats.push_back(stamp_counts(res));
		end else begin
			// 0 or anything past the depth means a full-depth batch
			batch = int'(beat.batch_limit);
			if (batch == 0 || batch > QUEUE_DEPTH)
				batch = QUEUE_DEPTH;
			if (batch > RESULT_CAP)
				batch = RESULT_CAP;
			drained = 0;
			while (drained < batch && fill_level > 0) begin
				res              = '0;
				res.entry_valid  = 1'b1;
				res.out_handler  = slot_handler[head_idx];
				res.out_argument = slot_argument[head_idx];
				res.out_sequence = slot_seq[head_idx];
				head_idx         = (head_idx + 1) % QUEUE_DEPTH;
				fill_level--;
				drained_tally    = drained_tally + 1'b1;
				drained++;
				res.ran_so_far   = COUNT_W'(drained);
				res.last         = (drained == batch || fill_level == 0);
				owed_beats.push_back(stamp_counts(res));
			end
			// nothing to drain: a single empty beat
			if (drained == 0) begin
				res      = '0;
				res.last = 1'b1;
				owed_beats.push_back(stamp_counts(res));
			end
		end
	endtask

	task automatic flag_error(input string what, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		errors_seen++;
		if (errors_seen <= 10)
			$display("%0t: rsp %s mismatch: expected %0h, got %0h", $realtime, what, want,
				got);
	endtask

	task automatic compare_beat(input wdf_rsp_t want, input wdf_rsp_t got);
		if (got.accepted !== want.accepted)
			flag_error("accepted", WORD_W'(want.accepted), WORD_W'(got.accepted));
		if (got.entry_valid !== want.entry_valid)
			flag_error("entry_valid", WORD_W'(want.entry_valid), WORD_W'(got.entry_valid));
		if (got.out_handler !== want.out_handler)
			flag_error("out_handler", WORD_W'(want.out_handler), WORD_W'(got.out_handler));
		if (got.out_argument !== want.out_argument)
			flag_error("out_argument", want.out_argument, got.out_argument);
		if (got.out_sequence !== want.out_sequence)
			flag_error("out_sequence", want.out_sequence, got.out_sequence);
		if (got.ran_so_far !== want.ran_so_far)
			flag_error("ran_so_far", WORD_W'(want.ran_so_far), WORD_W'(got.ran_so_far));
		if (got.last !== want.last)
			flag_error("last", WORD_W'(want.last), WORD_W'(got.last));
		if (got.pending_count !== want.pending_count)
			flag_error("pending_count", WORD_W'(want.pending_count),
				WORD_W'(got.pending_count));
		if (got.executed_total !== want.executed_total)
			flag_error("executed_total", want.executed_total, got.executed_total);
		if (got.dropped_total !== want.dropped_total)
			flag_error("dropped_total", want.dropped_total, got.dropped_total);
	endtask

	// Watch both channels; result beats are checked before a same-edge request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_idx      = 0;
			tail_idx      = 0;
			fill_level    = 0;
			seq_next      = 64'd1;
			drained_tally = '0;
			dropped_tally = '0;
			owed_beats.delete();
			errors_seen   = 0;
			error_count   <= 0;
			results_owed  <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (owed_beats.size() == 0)
					flag_error("beat with none owed", '0, rsp.out_sequence);
				else
					compare_beat(owed_beats.pop_front(), rsp);
			end
			if (req_valid && !req_stall)
				predict_request(req);
			error_count  <= errors_seen;
			results_owed <= owed_beats.size();
		end
	end

endmodule

@@ verif/work_descriptor_fifo_test.sv @@
`timescale 1ns / 100ps

module work_descriptor_fifo_test;
	import wdf_pkg::*;

	localparam int IDLE_LIMIT  = 4000;
	localparam int DRAIN_WAIT  = 8;
	localparam int RANDOM_BODY = 180;
	localparam int FLOOD_LEN   = 68;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	wdf_req_t req;
	logic     rsp_valid;
	logic     rsp_stall;
	wdf_rsp_t rsp;
	int       error_count;
	int       results_owed;

	// no idling on either side while set
	bit calm;
	int idle_cycles;
	int stall_hold;
	int stall_len;

	work_descriptor_fifo u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	work_descriptor_fifo_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp),
		.error_count  (error_count),
		.results_owed (results_owed)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic wdf_req_t make_req(input logic cmd, input logic [HANDLER_W-1:0] hnd,
			input logic [WORD_W-1:0] arg, input logic [COUNT_W-1:0] lim);
		wdf_req_t beat;
		beat.command     = cmd;
		beat.handler     = hnd;
		beat.argument    = arg;
		beat.batch_limit = lim;
		return beat;
	endfunction

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic wdf_req_t rand_schedule();
		return make_req(CMD_SCHEDULE, $urandom | 32'd1, rand_word(), COUNT_W'($urandom));
	endfunction

	// random beat: zero and all-ones handlers, oversized limits mixed in
	function automatic wdf_req_t rand_request();
		logic [HANDLER_W-1:0] hnd;
		logic [COUNT_W-1:0]   lim;
		int                   r;
		r = $urandom_range(0, 99);
		if (r < 6)
			hnd = '0;
		else if (r < 10)
			hnd = '1;
		else
			hnd = $urandom;
		r = $urandom_range(0, 99);
		if (r < 10)
			lim = '0;
		else if (r < 60)
			lim = COUNT_W'($urandom_range(1, 6));
		else if (r < 85)
			lim = COUNT_W'($urandom_range(7, 64));
		else
			lim = COUNT_W'($urandom_range(65, 127));
		return make_req(($urandom_range(0, 99) < 55) ? CMD_SCHEDULE : CMD_RUN, hnd,
			rand_word(), lim);
	endfunction

	// Present one request beat and hold it until taken
	task automatic send_req(input wdf_req_t beat);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= beat;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// Hold off the sender until every owed result beat has arrived
	task automatic drain_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
	endtask

	// Result side stall pattern
	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else begin
			stall_len = pick_gap();
			if (calm || stall_len == 0) begin
				rsp_stall  <= 1'b0;
				stall_hold <= $urandom_range(0, 4);
			end else begin
				rsp_stall  <= 1'b1;
				stall_hold <= stall_len - 1;
			end
		end
	end

	// Watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req         = '0;
		rsp_stall   = 1'b0;
		calm        = 1'b0;
		idle_cycles = 0;
		stall_hold  = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty runs, refused and extreme schedules, batch limit corners
		send_req(make_req(CMD_RUN, '0, '0, '0));
		send_req(make_req(CMD_SCHEDULE, '0, '1, '1));
		send_req(make_req(CMD_SCHEDULE, '1, '1, '0));
		send_req(make_req(CMD_SCHEDULE, 32'd1, '0, 7'd1));
		send_req(make_req(CMD_SCHEDULE, 32'h8000_0000, 64'h8000_0000_0000_0000, '1));
		send_req(make_req(CMD_RUN, '1, '1, 7'd1));
		send_req(make_req(CMD_RUN, '0, '0, '1));
		send_req(make_req(CMD_RUN, '0, '0, 7'd64));
		send_req(make_req(CMD_SCHEDULE, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, '0));
		send_req(make_req(CMD_SCHEDULE, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555, '0));
		send_req(make_req(CMD_SCHEDULE, 32'h0000_FFFF, 64'h0123_4567_89AB_CDEF, '0));
		send_req(make_req(CMD_RUN, '0, '0, 7'd65));
		send_req(make_req(CMD_SCHEDULE, 32'h7FFF_FFFF, 64'hFFFF_FFFF_0000_0000, '0));
		send_req(make_req(CMD_SCHEDULE, 32'h0000_0002, 64'h0000_0000_FFFF_FFFF, '0));
		send_req(make_req(CMD_RUN, '0, '0, 7'd64));
		send_req(make_req(CMD_RUN, '0, '0, 7'd1));

		// Random body with two floods past full depth, each after a full drain
		for (int step = 0; step < RANDOM_BODY; step++) begin
			if (step % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (step == 60 || step == 130) begin
				drain_results();
				repeat (FLOOD_LEN) send_req(rand_schedule());
				send_req(make_req(CMD_SCHEDULE, '0, rand_word(), '0));
				send_req(make_req(CMD_RUN, $urandom, rand_word(), '0));
			end
			send_req(rand_request());
		end

		drain_results();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ work_descriptor_fifo.f @@
+incdir+src
src/wdf_pkg.sv
src/wdf_ring.sv
src/work_descriptor_fifo.sv
verif/work_descriptor_fifo_checker.sv
verif/work_descriptor_fifo_test.sv
